### design/pidaw_pkg.sv
package pidaw_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int GAIN_BITS = 31;
   localparam int OPND_BITS = 33;
   localparam int PROD_BITS = 66;
   localparam int WIDE_BITS = 68;
   localparam int DIVD_BITS = 67;
   localparam int DIVS_BITS = 33;

   localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic [GAIN_BITS-1:0] PERIOD_RESET = 31'd65536;

   // 2*pi and its half in Q16.16
   localparam logic [DIVS_BITS-1:0] WRAP_PERIOD = 33'd411775;
   localparam logic signed [33:0] WRAP_PERIOD_S = 34'sd411775;
   localparam logic signed [33:0] WRAP_HALF_S = 34'sd205887;
   // floor(2^32 / period), the quotient it gives is exact or one short
   localparam logic signed [OPND_BITS-1:0] WRAP_RECIP = 33'sd10430;

   typedef enum logic [2:0] {
      REG_GAIN_P = 3'd0,
      REG_GAIN_I = 3'd1,
      REG_GAIN_D = 3'd2,
      REG_PERIOD = 3'd3,
      REG_TAU = 3'd4,
      REG_OUT_MIN = 3'd5,
      REG_OUT_MAX = 3'd6,
      REG_SIMPLE = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR,
      ST_WRAP_GO,
      ST_WRAP_Q,
      ST_WRAP_R,
      ST_WRAP_FIX,
      ST_MODE,
      ST_F_P,
      ST_F_PW,
      ST_F_KW,
      ST_F_X,
      ST_F_XW,
      ST_F_CL,
      ST_F_D1,
      ST_F_D2,
      ST_F_DG,
      ST_F_DW,
      ST_F_SUM,
      ST_S_P,
      ST_S_D,
      ST_S_I,
      ST_S_F,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [DIVD_BITS-1:0] dividend;
      logic [DIVS_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIVD_BITS-1:0] quotient;
      logic [DIVS_BITS-1:0] remainder;
   } div_rsp_type;

   function automatic logic signed [WORD_BITS-1:0] sat_wide(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v < WIDE_BITS'(WORD_MIN)) begin
         r = WORD_MIN;
      end else if (v > WIDE_BITS'(WORD_MAX)) begin
         r = WORD_MAX;
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sat_add(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
      return sat_wide(WIDE_BITS'(a) + WIDE_BITS'(b));
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sat_sub(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
      return sat_wide(WIDE_BITS'(a) - WIDE_BITS'(b));
   endfunction

endpackage

### design/pidaw_mul.sv
module pidaw_mul (
   input  logic clock,
   input  logic signed [pidaw_pkg::OPND_BITS-1:0] op_a,
   input  logic signed [pidaw_pkg::OPND_BITS-1:0] op_b,
   output logic signed [pidaw_pkg::PROD_BITS-1:0] prod_ff
);
   logic signed [pidaw_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = pidaw_pkg::PROD_BITS'(op_a) * pidaw_pkg::PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

### design/pidaw_div.sv
module pidaw_div (
   input  logic clock,
   input  logic reset,
   input  pidaw_pkg::div_req_type req,
   output pidaw_pkg::div_rsp_type rsp
);
   localparam int CNT_BITS = $clog2(pidaw_pkg::DIVD_BITS + 1);

   logic [pidaw_pkg::DIVD_BITS-1:0] quo_ff, quo_in;
   logic [pidaw_pkg::DIVS_BITS-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [pidaw_pkg::DIVS_BITS:0] trial;
   logic ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, quo_ff[pidaw_pkg::DIVD_BITS-1]};
      ge = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = CNT_BITS'(pidaw_pkg::DIVD_BITS);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[pidaw_pkg::DIVD_BITS-2:0], ge};
         rem_in = ge ? pidaw_pkg::DIVS_BITS'(trial - {1'b0, dsr_ff})
                     : trial[pidaw_pkg::DIVS_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         done_in = cnt_ff == CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

### design/pid_controller_antiwindup_unit.sv
// PID controller with anti-windup in signed Q16.16. A transaction carries target and
// measured (tdata) and an angle-wrap flag (tuser) and returns the drive and the error used.
// In full mode the result waits on the 67-step bit-serial divider of the filtered
// derivative. Angle wrap adds a reciprocal multiply, a multiply back by 2*pi, the
// remainder and the fold. One shared 33x33 multiplier does every product. A finished result
// sits in an output register, so the next transaction is taken while it waits; a result
// stalled longer than the next computation holds the block in its final step. Configuration
// is to be written by the user only while idle; the block itself does not enforce it.
module pid_controller_antiwindup_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,   // target, measured
   input  logic req_tuser,          // angle_wrap
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [63:0] rsp_tdata,   // drive, error_value
   input  logic csr_we,
   input  logic [2:0] csr_addr,
   input  logic [31:0] csr_wdata
);
   localparam int W = pidaw_pkg::WORD_BITS;
   localparam int WB = pidaw_pkg::WIDE_BITS;
   localparam int OB = pidaw_pkg::OPND_BITS;
   localparam int GB = pidaw_pkg::GAIN_BITS;
   localparam int FB = pidaw_pkg::FRAC_BITS;

   pidaw_pkg::state_type state_ff, state_in;

   logic [GB-1:0] gp_ff, gi_ff, gd_ff, period_ff, tau_ff;
   logic signed [W-1:0] omin_ff, omax_ff;
   logic simple_ff;

   logic signed [W-1:0] tgt_ff, tgt_in, meas_ff, meas_in;
   logic wrap_ff, wrap_in;
   logic signed [W-1:0] e_ff, e_in, p_ff, p_in, kt_ff, kt_in, esum_ff, esum_in;
   logic signed [W-1:0] integ_ff, integ_in, lerr_ff, lerr_in, deriv_ff, deriv_in;
   logic signed [W-1:0] lmeas_ff, lmeas_in, dm_ff, dm_in, edot_ff, edot_in;
   logic signed [W-1:0] res_ff, res_in;
   logic signed [WB-1:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic rv_ff, rv_in;
   logic signed [W-1:0] rdrive_ff, rdrive_in, rerr_ff, rerr_in;

   logic signed [OB-1:0] mul_a, mul_b;
   logic signed [pidaw_pkg::PROD_BITS-1:0] prod;
   pidaw_pkg::div_req_type dreq;
   pidaw_pkg::div_rsp_type drsp;

   logic [GB-1:0] t_eff;
   logic signed [OB-1:0] tau_m_t;
   logic [pidaw_pkg::DIVS_BITS-1:0] tau_p_t;
   logic [OB-1:0] emag;
   logic signed [WB-1:0] nmag, qs, total, sacc, rfix;
   logic signed [33:0] wr;
   logic signed [W-1:0] hi_lim, lo_lim, xi;

   pidaw_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));
   pidaw_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= '0;
         gi_ff <= '0;
         gd_ff <= '0;
         period_ff <= pidaw_pkg::PERIOD_RESET;
         tau_ff <= '0;
         omin_ff <= pidaw_pkg::WORD_MIN;
         omax_ff <= pidaw_pkg::WORD_MAX;
         simple_ff <= 1'b0;
      end else if (csr_we) begin
         case (pidaw_pkg::reg_index_type'(csr_addr))
            pidaw_pkg::REG_GAIN_P: gp_ff <= csr_wdata[GB-1:0];
            pidaw_pkg::REG_GAIN_I: gi_ff <= csr_wdata[GB-1:0];
            pidaw_pkg::REG_GAIN_D: gd_ff <= csr_wdata[GB-1:0];
            pidaw_pkg::REG_PERIOD: period_ff <= csr_wdata[GB-1:0];
            pidaw_pkg::REG_TAU: tau_ff <= csr_wdata[GB-1:0];
            pidaw_pkg::REG_OUT_MIN: omin_ff <= csr_wdata;
            pidaw_pkg::REG_OUT_MAX: omax_ff <= csr_wdata;
            pidaw_pkg::REG_SIMPLE: simple_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      t_eff = (period_ff == '0) ? GB'(1) : period_ff;
      tau_m_t = $signed({1'b0, tau_ff, 1'b0}) - $signed({2'b00, t_eff});
      tau_p_t = {1'b0, tau_ff, 1'b0} + {2'b00, t_eff};
      emag = e_ff[W-1] ? (OB'(0) - OB'(e_ff)) : OB'(e_ff);
      nmag = acc_ff[WB-1] ? (WB'(0) - acc_ff) : acc_ff;
      qs = $signed({1'b0, drsp.quotient});
      // remainder of |e| by 2*pi, from a quotient that may be one short
      rfix = (acc_ff >= WB'(pidaw_pkg::WRAP_PERIOD_S))
             ? (acc_ff - WB'(pidaw_pkg::WRAP_PERIOD_S)) : acc_ff;
      wr = e_ff[W-1] ? (34'sd0 - $signed(rfix[33:0])) : $signed(rfix[33:0]);
      if (wr < 34'sd0) begin
         wr = wr + pidaw_pkg::WRAP_PERIOD_S;
      end
      if (wr > pidaw_pkg::WRAP_HALF_S) begin
         wr = wr - pidaw_pkg::WRAP_PERIOD_S;
      end
      xi = pidaw_pkg::sat_wide(WB'(prod >>> FB));
      hi_lim = (omax_ff > p_ff) ? pidaw_pkg::sat_sub(omax_ff, p_ff) : '0;
      lo_lim = (omin_ff < p_ff) ? pidaw_pkg::sat_sub(omin_ff, p_ff) : '0;
      total = WB'(p_ff) + WB'(integ_ff) + WB'(deriv_ff);
      sacc = acc_ff + WB'(prod);
   end

   always_comb begin
      state_in = state_ff;
      tgt_in = tgt_ff;
      meas_in = meas_ff;
      wrap_in = wrap_ff;
      e_in = e_ff;
      p_in = p_ff;
      kt_in = kt_ff;
      esum_in = esum_ff;
      integ_in = integ_ff;
      lerr_in = lerr_ff;
      deriv_in = deriv_ff;
      lmeas_in = lmeas_ff;
      dm_in = dm_ff;
      edot_in = edot_ff;
      res_in = res_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      rv_in = rv_ff & ~rsp_tready;
      rdrive_in = rdrive_ff;
      rerr_in = rerr_ff;
      mul_a = '0;
      mul_b = '0;
      dreq.start = 1'b0;
      dreq.dividend = nmag[pidaw_pkg::DIVD_BITS-1:0];
      dreq.divisor = tau_p_t;
      req_tready = 1'b0;
      case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               tgt_in = req_tdata[W-1:0];
               meas_in = req_tdata[2*W-1:W];
               wrap_in = req_tuser;
               state_in = pidaw_pkg::ST_ERR;
            end
         end
         pidaw_pkg::ST_ERR: begin
            e_in = pidaw_pkg::sat_sub(tgt_ff, meas_ff);
            state_in = wrap_ff ? pidaw_pkg::ST_WRAP_GO : pidaw_pkg::ST_MODE;
         end
         pidaw_pkg::ST_WRAP_GO: begin
            mul_a = $signed(emag);
            mul_b = pidaw_pkg::WRAP_RECIP;
            state_in = pidaw_pkg::ST_WRAP_Q;
         end
         pidaw_pkg::ST_WRAP_Q: begin
            mul_a = prod[pidaw_pkg::PROD_BITS-2:32];
            mul_b = $signed(pidaw_pkg::WRAP_PERIOD);
            state_in = pidaw_pkg::ST_WRAP_R;
         end
         pidaw_pkg::ST_WRAP_R: begin
            acc_in = $signed(WB'(emag)) - WB'(prod);
            state_in = pidaw_pkg::ST_WRAP_FIX;
         end
         pidaw_pkg::ST_WRAP_FIX: begin
            e_in = wr[W-1:0];
            state_in = pidaw_pkg::ST_MODE;
         end
         pidaw_pkg::ST_MODE: begin
            state_in = simple_ff ? pidaw_pkg::ST_S_P : pidaw_pkg::ST_F_P;
         end
         pidaw_pkg::ST_F_P: begin
            mul_a = $signed({2'b00, gp_ff});
            mul_b = OB'(e_ff);
            state_in = pidaw_pkg::ST_F_PW;
         end
         pidaw_pkg::ST_F_PW: begin
            p_in = xi;
            mul_a = $signed({2'b00, gi_ff});
            mul_b = $signed({2'b00, t_eff});
            state_in = pidaw_pkg::ST_F_KW;
         end
         pidaw_pkg::ST_F_KW: begin
            kt_in = pidaw_pkg::sat_wide(WB'(prod >>> (FB + 1)));
            esum_in = pidaw_pkg::sat_add(e_ff, lerr_ff);
            state_in = pidaw_pkg::ST_F_X;
         end
         pidaw_pkg::ST_F_X: begin
            mul_a = OB'(kt_ff);
            mul_b = OB'(esum_ff);
            state_in = pidaw_pkg::ST_F_XW;
         end
         pidaw_pkg::ST_F_XW: begin
            integ_in = pidaw_pkg::sat_add(integ_ff, xi);
            dm_in = pidaw_pkg::sat_sub(meas_ff, lmeas_ff);
            state_in = pidaw_pkg::ST_F_CL;
         end
         pidaw_pkg::ST_F_CL: begin
            if (integ_ff > hi_lim) begin
               integ_in = hi_lim;
            end else if (integ_ff < lo_lim) begin
               integ_in = lo_lim;
            end
            mul_a = $signed({1'b0, gd_ff, 1'b0});
            mul_b = OB'(dm_ff);
            state_in = pidaw_pkg::ST_F_D1;
         end
         pidaw_pkg::ST_F_D1: begin
            acc_in = WB'(prod);
            mul_a = tau_m_t;
            mul_b = OB'(deriv_ff);
            state_in = pidaw_pkg::ST_F_D2;
         end
         pidaw_pkg::ST_F_D2: begin
            acc_in = sacc;
            state_in = pidaw_pkg::ST_F_DG;
         end
         pidaw_pkg::ST_F_DG: begin
            dreq.start = 1'b1;
            neg_in = acc_ff[WB-1];
            state_in = pidaw_pkg::ST_F_DW;
         end
         pidaw_pkg::ST_F_DW: begin
            if (drsp.done) begin
               deriv_in = neg_ff ? pidaw_pkg::sat_wide(qs)
                                 : pidaw_pkg::sat_wide(WB'(0) - qs);
               state_in = pidaw_pkg::ST_F_SUM;
            end
         end
         pidaw_pkg::ST_F_SUM: begin
            if (total > WB'(omax_ff)) begin
               res_in = omax_ff;
            end else if (total < WB'(omin_ff)) begin
               res_in = omin_ff;
            end else begin
               res_in = total[W-1:0];
            end
            lerr_in = e_ff;
            lmeas_in = meas_ff;
            state_in = pidaw_pkg::ST_DONE;
         end
         pidaw_pkg::ST_S_P: begin
            mul_a = $signed({2'b00, gp_ff});
            mul_b = OB'(e_ff);
            edot_in = pidaw_pkg::sat_sub(e_ff, lerr_ff);
            integ_in = pidaw_pkg::sat_add(integ_ff, e_ff);
            state_in = pidaw_pkg::ST_S_D;
         end
         pidaw_pkg::ST_S_D: begin
            acc_in = WB'(prod);
            mul_a = $signed({2'b00, gd_ff});
            mul_b = OB'(edot_ff);
            state_in = pidaw_pkg::ST_S_I;
         end
         pidaw_pkg::ST_S_I: begin
            acc_in = sacc;
            mul_a = $signed({2'b00, gi_ff});
            mul_b = OB'(integ_ff);
            state_in = pidaw_pkg::ST_S_F;
         end
         pidaw_pkg::ST_S_F: begin
            res_in = pidaw_pkg::sat_wide(sacc >>> FB);
            lerr_in = e_ff;
            state_in = pidaw_pkg::ST_DONE;
         end
         pidaw_pkg::ST_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rdrive_in = res_ff;
               rerr_in = e_ff;
               state_in = pidaw_pkg::ST_IDLE;
            end
         end
         default: state_in = pidaw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidaw_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         integ_ff <= '0;
         lerr_ff <= '0;
         deriv_ff <= '0;
         lmeas_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         integ_ff <= integ_in;
         lerr_ff <= lerr_in;
         deriv_ff <= deriv_in;
         lmeas_ff <= lmeas_in;
      end
      tgt_ff <= tgt_in;
      meas_ff <= meas_in;
      wrap_ff <= wrap_in;
      e_ff <= e_in;
      p_ff <= p_in;
      kt_ff <= kt_in;
      esum_ff <= esum_in;
      dm_ff <= dm_in;
      edot_ff <= edot_in;
      res_ff <= res_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      rdrive_ff <= rdrive_in;
      rerr_ff <= rerr_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {rerr_ff, rdrive_ff};
endmodule

### design/pidaw_checker.sv
module pidaw_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [63:0] rsp_tdata
);
   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a transaction keeps the input side closed while it is worked on
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // a new result only appears from the final step, never straight from idle
   a_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result without work");
endmodule

bind pid_controller_antiwindup_unit pidaw_checker u_pidaw_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic signed [31:0] err;
      logic signed [31:0] drive;
   } pid_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   pid_controller_antiwindup_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state and configuration
   logic [30:0] kp, ki, kd, per, tau;
   logic signed [31:0] omin, omax;
   logic smode;
   logic signed [31:0] integ, prev_err, deriv, prev_meas;

   pid_out_type pending_q[$];
   int n_fail = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_wrap = 0;
   int idle_cnt = 0;

   function automatic logic signed [31:0] clip(input logic signed [127:0] v);
      if (v < -128'sd2147483648) return 32'sh8000_0000;
      if (v > 128'sd2147483647) return 32'sh7fff_ffff;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fmul(input logic signed [127:0] a,
                                               input logic signed [127:0] b, input int sh);
      logic signed [127:0] pr;
      pr = (a * b) >>> sh;
      return clip(pr);
   endfunction

   function automatic pid_out_type pid_predict(input logic signed [31:0] tgt,
                                               input logic signed [31:0] meas,
                                               input logic wrap);
      pid_out_type r;
      logic signed [127:0] e, rm, s, num, q, tot;
      logic signed [127:0] t, hi_l, lo_l, pv, kt, dm, dv;
      logic signed [31:0] ew, dmw;
      e = 128'(tgt) - 128'(meas);
      ew = clip(e);
      if (wrap) begin
         rm = 128'(ew) % 128'sd411775;
         if (rm < 0) rm = rm + 128'sd411775;
         if (rm > 128'sd205887) rm = rm - 128'sd411775;
         ew = clip(rm);
      end
      if (smode) begin
         dmw = clip(128'(ew) - 128'(prev_err));
         integ = clip(128'(integ) + 128'(ew));
         s = 128'($signed({1'b0, kp})) * 128'(ew) + 128'($signed({1'b0, kd})) * 128'(dmw)
             + 128'($signed({1'b0, ki})) * 128'(integ);
         r.drive = clip(s >>> pidaw_pkg::FRAC_BITS);
         prev_err = ew;
      end else begin
         t = (per == 0) ? 128'sd1 : 128'($signed({1'b0, per}));
         pv = fmul(128'($signed({1'b0, kp})), 128'(ew), pidaw_pkg::FRAC_BITS);
         kt = fmul(128'($signed({1'b0, ki})), t, pidaw_pkg::FRAC_BITS + 1);
         integ = clip(128'(integ)
            + 128'(fmul(kt, 128'(clip(128'(ew) + 128'(prev_err))), pidaw_pkg::FRAC_BITS)));
         hi_l = (128'(omax) > pv) ? 128'(clip(128'(omax) - pv)) : 128'sd0;
         lo_l = (128'(omin) < pv) ? 128'(clip(128'(omin) - pv)) : 128'sd0;
         if (128'(integ) > hi_l) integ = hi_l[31:0];
         else if (128'(integ) < lo_l) integ = lo_l[31:0];
         dmw = clip(128'(meas) - 128'(prev_meas));
         dm = dmw;
         num = 128'sd2 * 128'($signed({1'b0, kd})) * dm
               + (128'sd2 * 128'($signed({1'b0, tau})) - t) * 128'(deriv);
         dv = 128'sd2 * 128'($signed({1'b0, tau})) + t;
         q = num / dv;
         deriv = clip(-q);
         tot = pv + 128'(integ) + 128'(deriv);
         if (tot > 128'(omax)) r.drive = omax;
         else if (tot < 128'(omin)) r.drive = omin;
         else r.drive = tot[31:0];
         prev_err = ew;
         prev_meas = meas;
      end
      r.err = ew;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
      n_fail++;
   endtask

   // result side
   initial begin
      int hold;
      pid_out_type got, want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_q.size() == 0) begin
               report_mismatch("unexpected result", got.drive, 32'h0);
            end else begin
               want = pending_q.pop_front();
               if (got.drive !== want.drive) report_mismatch("drive", got.drive, want.drive);
               if (got.err !== want.err) report_mismatch("error", got.err, want.err);
            end
            n_checked++;
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end else if (rsp_tvalid && hold != 0) begin
            hold--;
         end
         if (!reset) begin
            rsp_tready <= (hold == 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
         $display("pid_controller_antiwindup_unit verification failed");
         $finish;
      end
   end

   task automatic write_reg(input pidaw_pkg::reg_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         pidaw_pkg::REG_GAIN_P: kp = val[30:0];
         pidaw_pkg::REG_GAIN_I: ki = val[30:0];
         pidaw_pkg::REG_GAIN_D: kd = val[30:0];
         pidaw_pkg::REG_PERIOD: per = val[30:0];
         pidaw_pkg::REG_TAU: tau = val[30:0];
         pidaw_pkg::REG_OUT_MIN: omin = val;
         pidaw_pkg::REG_OUT_MAX: omax = val;
         pidaw_pkg::REG_SIMPLE: smode = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // tvalid stays high into the next transaction when there is no gap
   task automatic send_item(input logic [31:0] tgt, input logic [31:0] meas,
                            input logic wrap);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {meas, tgt};
      req_tuser <= wrap;
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(pid_predict(tgt, meas, wrap));
      n_sent++;
      n_wrap += wrap;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 400000) - 200000;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_item(32'h7fff_ffff, 32'h8000_0000, 1'b1);
      send_item(32'h0003_2440, 32'h0, 1'b1);
      send_item(32'h0003_243f, 32'h0, 1'b1);
      send_item(32'hfffc_dbc0, 32'h0, 1'b1);
      send_item(32'h0, 32'h0, 1'b0);
      drain();
      write_reg(pidaw_pkg::REG_GAIN_P, 32'hffff_ffff);
      write_reg(pidaw_pkg::REG_GAIN_I, 32'h0001_0000);
      write_reg(pidaw_pkg::REG_GAIN_D, 32'h0002_0000);
      write_reg(pidaw_pkg::REG_PERIOD, 32'h0);
      write_reg(pidaw_pkg::REG_TAU, 32'h7fff_ffff);
      write_reg(pidaw_pkg::REG_OUT_MIN, 32'h0001_0000);
      write_reg(pidaw_pkg::REG_OUT_MAX, 32'hffff_0000);
      send_item(32'h0010_0000, 32'h0, 1'b0);
      send_item(32'hfff0_0000, 32'h0005_0000, 1'b0);
      send_item(32'h1234_5678, 32'h8000_0000, 1'b1);
      drain();
      write_reg(pidaw_pkg::REG_SIMPLE, 32'hffff_ffff);
      send_item(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_item(32'h7fff_ffff, 32'h0, 1'b0);
      send_item(32'h8000_0000, 32'h0, 1'b1);
      send_item(32'h0, 32'h0, 1'b0);
      drain();
   endtask

   task automatic test_random(input int phases, input int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         write_reg(pidaw_pkg::REG_GAIN_P, rand_gain());
         write_reg(pidaw_pkg::REG_GAIN_I, rand_gain());
         write_reg(pidaw_pkg::REG_GAIN_D, rand_gain());
         write_reg(pidaw_pkg::REG_PERIOD, $urandom_range(0, 3) == 0 ? rand_gain() :
                   $urandom_range(0, 32'h0002_0000));
         write_reg(pidaw_pkg::REG_TAU, rand_gain());
         if ($urandom_range(0, 1)) begin
            write_reg(pidaw_pkg::REG_OUT_MIN,
                      $urandom_range(0, 3) == 0 ? rand_word() : 32'hfff0_0000);
            write_reg(pidaw_pkg::REG_OUT_MAX,
                      $urandom_range(0, 3) == 0 ? rand_word() : 32'h0010_0000);
         end
         write_reg(pidaw_pkg::REG_SIMPLE, 32'($urandom_range(0, 2) == 0));
         for (int i = 0; i < per_phase; i++) begin
            send_item(rand_word(), rand_word(), 1'($urandom_range(0, 1)));
         end
         drain();
      end
   endtask

   initial begin
      kp = '0; ki = '0; kd = '0; per = 31'd65536; tau = '0;
      omin = 32'sh8000_0000; omax = 32'sh7fff_ffff; smode = 1'b0;
      integ = '0; prev_err = '0; deriv = '0; prev_meas = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(26, 30);
      $display("%0d transactions sent (%0d angle-wrapped), %0d results checked",
               n_sent, n_wrap, n_checked);
      $display("covered full and simple modes, extreme gains, limits and periods");
      if (n_fail == 0 && pending_q.size() == 0) begin
         $display("pid_controller_antiwindup_unit verification clean");
      end else begin
         $display("pid_controller_antiwindup_unit verification failed");
      end
      $finish;
   end
endmodule

### files.f
design/pidaw_pkg.sv
design/pidaw_mul.sv
design/pidaw_div.sv
design/pid_controller_antiwindup_unit.sv
design/pidaw_checker.sv
test/tb_top.sv
